FILE: sv/mvt_pkg.sv
// Shared types and constants for the 4x4 matrix-vector transform.
// Used by mvt_lane, mvt_merge and matrix4_vector_transform; no dependencies.
package mvt_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_W    = 32;
    localparam int ROWS      = 4;
    localparam int COLS      = 4;
    localparam int PROD_W    = 2 * WORD_W;
    localparam int PAIR_W    = PROD_W + 1;
    localparam int ACC_W     = PROD_W + 2;

    localparam int NUM_REGS  = 8;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_SEL_W = $clog2(NUM_REGS);

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [PAIR_W-1:0] t_pair;
    typedef logic signed [ACC_W-1:0]  t_acc;

    typedef struct packed {
        logic [WORD_W-1:0] res;
        logic              sat;
    } t_lane_res;

    localparam logic [WORD_W-1:0] SAT_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] SAT_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    // identity matrix: ones on the diagonal, Q16.16
    localparam logic [CFG_DATA_W-1:0] CFG_RESET [NUM_REGS] = '{
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000
    };

endpackage

FILE: sv/mvt_lane.sv
// One row lane: four registered multipliers, a two-level registered adder tree,
// then arithmetic shift and saturation to a word. Depends on mvt_pkg.
module mvt_lane (
    input  logic               i_clk,
    input  logic               i_en,
    input  mvt_pkg::t_word     i_row [mvt_pkg::COLS],
    input  mvt_pkg::t_word     i_vec [mvt_pkg::COLS],
    output mvt_pkg::t_lane_res o_res
);
    import mvt_pkg::*;

    t_prod r_prod [COLS];
    t_pair r_pair [2];
    t_acc  r_sum;
    t_acc  w_shifted;
    logic  w_fits;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < COLS; c++) begin
                r_prod[c] <= t_prod'(i_row[c]) * t_prod'(i_vec[c]);
            end
            r_pair[0] <= t_pair'(r_prod[0]) + t_pair'(r_prod[1]);
            r_pair[1] <= t_pair'(r_prod[2]) + t_pair'(r_prod[3]);
            r_sum     <= t_acc'(r_pair[0]) + t_acc'(r_pair[1]);
        end
    end

    // floor the fraction away; in range when all bits from the top down to the word's sign bit agree
    assign w_shifted = r_sum >>> FRAC_BITS;
    assign w_fits    = (&w_shifted[ACC_W-1:WORD_W-1]) || !(|w_shifted[ACC_W-1:WORD_W-1]);

    always_comb begin
        o_res.sat = !w_fits;
        if (w_fits) begin
            o_res.res = w_shifted[WORD_W-1:0];
        end else if (r_sum[ACC_W-1]) begin
            o_res.res = SAT_MIN;
        end else begin
            o_res.res = SAT_MAX;
        end
    end

endmodule

FILE: sv/mvt_merge.sv
// Output stage: gathers the four lane results into one beat and ORs the
// saturation flags. Depends on mvt_pkg.
module mvt_merge (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  mvt_pkg::t_lane_res i_lane [mvt_pkg::ROWS],
    output logic               o_valid,
    output mvt_pkg::t_word     o_res_x,
    output mvt_pkg::t_word     o_res_y,
    output mvt_pkg::t_word     o_res_z,
    output mvt_pkg::t_word     o_res_w,
    output logic               o_saturated
);
    import mvt_pkg::*;

    logic  r_valid;
    t_word r_res [ROWS];
    logic  r_sat;
    logic  n_sat;

    always_comb begin
        n_sat = 1'b0;
        for (int r = 0; r < ROWS; r++) begin
            n_sat = n_sat | i_lane[r].sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < ROWS; r++) begin
                r_res[r] <= i_lane[r].res;
            end
            r_sat <= n_sat;
        end
    end

    assign o_valid     = r_valid;
    assign o_res_x     = r_res[0];
    assign o_res_y     = r_res[1];
    assign o_res_z     = r_res[2];
    assign o_res_w     = r_res[3];
    assign o_saturated = r_sat;

endmodule

FILE: sv/matrix4_vector_transform.sv
// Top level of the 4x4 matrix-vector transform: matrix registers, four row
// lanes and the merge stage. Depends on mvt_pkg, mvt_lane and mvt_merge.
//
// Transforms one signed Q16.16 vector per clock by a signed Q16.16 4x4 matrix.
// The matrix sits in eight 64-bit registers written through the config port
// (two elements each, lower column in the low half; indexes above 7 are
// ignored); reset loads the identity. Each row has its own lane of four
// 32x32 multipliers feeding a registered adder tree, so a new vector is taken
// every cycle unless stalled; its result is registered as products, pair sums,
// full sum, then the shifted and saturated output beat. The whole pipeline
// advances together and holds only while the output beat is stalled, so a
// held result stalls the input in the same cycle. Write the matrix only while
// no vector is in flight.
module matrix4_vector_transform (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  mvt_pkg::t_word                      i_vec_x,
    input  mvt_pkg::t_word                      i_vec_y,
    input  mvt_pkg::t_word                      i_vec_z,
    input  mvt_pkg::t_word                      i_vec_w,
    output logic                                o_valid,
    input  logic                                i_stall,
    output mvt_pkg::t_word                      o_res_x,
    output mvt_pkg::t_word                      o_res_y,
    output mvt_pkg::t_word                      o_res_z,
    output mvt_pkg::t_word                      o_res_w,
    output logic                                o_saturated,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mvt_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mvt_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import mvt_pkg::*;

    logic [CFG_DATA_W-1:0] r_cfg [NUM_REGS];
    logic [2:0]            r_vld;
    logic                  w_adv;
    t_word                 w_vec [COLS];
    t_word                 w_row [ROWS][COLS];
    t_lane_res             w_lane [ROWS];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_cfg[i] <= CFG_RESET[i];
            end
        end else if (i_cfg_valid && (i_cfg_index < CFG_IDX_W'(NUM_REGS))) begin
            r_cfg[i_cfg_index[CFG_SEL_W-1:0]] <= i_cfg_data;
        end
    end

    // advance everything unless the output beat is held
    assign w_adv   = !o_valid || !i_stall;
    assign o_stall = !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    assign w_vec[0] = i_vec_x;
    assign w_vec[1] = i_vec_y;
    assign w_vec[2] = i_vec_z;
    assign w_vec[3] = i_vec_w;

    for (genvar r = 0; r < ROWS; r++) begin : g_lane
        assign w_row[r][0] = r_cfg[2*r][WORD_W-1:0];
        assign w_row[r][1] = r_cfg[2*r][CFG_DATA_W-1:WORD_W];
        assign w_row[r][2] = r_cfg[2*r+1][WORD_W-1:0];
        assign w_row[r][3] = r_cfg[2*r+1][CFG_DATA_W-1:WORD_W];

        mvt_lane u_lane (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_row (w_row[r]),
            .i_vec (w_vec),
            .o_res (w_lane[r])
        );
    end

    mvt_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_adv),
        .i_valid     (r_vld[2]),
        .i_lane      (w_lane),
        .o_valid     (o_valid),
        .o_res_x     (o_res_x),
        .o_res_y     (o_res_y),
        .o_res_z     (o_res_z),
        .o_res_w     (o_res_w),
        .o_saturated (o_saturated)
    );

endmodule

FILE: sim/testbench.sv
// Self-checking bench for matrix4_vector_transform: directed and random vectors under
// several matrix settings, with random idling and stalls on both streams.
// Depends on mvt_pkg and the block itself.
module testbench;

    localparam int HOLD_CYCLES    = 150;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 10;
    localparam int PHASE_VECTORS  = 75;
    localparam int FRAC           = mvt_pkg::FRAC_BITS;

    localparam logic [31:0] WORD_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] WORD_MIN = 32'h8000_0000;
    localparam logic [31:0] ONE_Q16  = 32'h0001_0000;

    typedef mvt_pkg::t_word t_word;

    typedef struct {
        t_word comp [4];
        logic  sat;
    } t_xform_result;

    class transform_tracker;
        logic [63:0]   mat_regs [8];
        t_xform_result expected_results [$];
        int            errors;
        int            vectors_seen;

        function new();
            mat_regs = '{64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
                         64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000};
            errors = 0;
            vectors_seen = 0;
        endfunction

        function void write_reg(logic [3:0] idx, logic [63:0] data);
            // drop writes to indexes past the last register
            if (idx < 8)
                mat_regs[idx[2:0]] = data;
        endfunction

        function t_xform_result predict_transform(t_word v [4]);
            t_xform_result      r;
            logic signed [67:0] acc;
            logic signed [67:0] shifted;
            logic [63:0]        word;
            t_word              m;
            mvt_pkg::t_prod     p;
            bit                 fits;
            r.sat = 1'b0;
            for (int row = 0; row < 4; row++) begin
                acc = '0;
                for (int col = 0; col < 4; col++) begin
                    word = mat_regs[row * 2 + col / 2];
                    m = (col % 2) ? word[63:32] : word[31:0];
                    p = mvt_pkg::t_prod'(m) * mvt_pkg::t_prod'(v[col]);
                    acc = acc + p;
                end
                shifted = acc >>> FRAC;
                fits = (shifted[67:31] == '0) || (shifted[67:31] == '1);
                if (fits) begin
                    r.comp[row] = shifted[31:0];
                end else begin
                    r.comp[row] = acc[67] ? WORD_MIN : WORD_MAX;
                    r.sat = 1'b1;
                end
            end
            return r;
        endfunction

        function void note_vector(t_word v [4]);
            expected_results.push_back(predict_transform(v));
            vectors_seen++;
        endfunction

        function void check_result(t_xform_result got);
            t_xform_result want;
            string         names [4];
            names = '{"res_x", "res_y", "res_z", "res_w"};
            if (expected_results.size() == 0) begin
                $error("result beat with nothing expected: %h %h %h %h sat %b",
                       got.comp[0], got.comp[1], got.comp[2], got.comp[3], got.sat);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            for (int i = 0; i < 4; i++) begin
                if (got.comp[i] !== want.comp[i]) begin
                    $error("%s: expected %h, actual %h", names[i], want.comp[i], got.comp[i]);
                    errors++;
                end
            end
            if (got.sat !== want.sat) begin
                $error("saturated: expected %b, actual %b", want.sat, got.sat);
                errors++;
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        o_stall;
    t_word       i_vec_x     = '0;
    t_word       i_vec_y     = '0;
    t_word       i_vec_z     = '0;
    t_word       i_vec_w     = '0;
    logic        o_valid;
    logic        i_stall     = 1'b0;
    t_word       o_res_x;
    t_word       o_res_y;
    t_word       o_res_z;
    t_word       o_res_w;
    logic        o_saturated;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [mvt_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [mvt_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;

    transform_tracker tracker = new();

    bit hold_req   = 1'b0;
    bit sink_quiet = 1'b0;
    bit src_quiet  = 1'b0;
    int idle_cycles = 0;
    int reg_writes  = 0;
    int settings    = 1;

    matrix4_vector_transform dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_vec_x     (i_vec_x),
        .i_vec_y     (i_vec_y),
        .i_vec_z     (i_vec_z),
        .i_vec_w     (i_vec_w),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_res_x     (o_res_x),
        .o_res_y     (o_res_y),
        .o_res_z     (o_res_z),
        .o_res_w     (o_res_w),
        .o_saturated (o_saturated),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin : result_monitor
        t_xform_result got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.comp[0] = o_res_x;
            got.comp[1] = o_res_y;
            got.comp[2] = o_res_z;
            got.comp[3] = o_res_w;
            got.sat     = o_saturated;
            tracker.check_result(got);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Output stall pattern: short runs mostly, a long stall now and then,
    // and one long hold-off on request.
    initial begin : stall_driver
        int   left;
        int   r;
        logic stall_now;
        left = 0;
        stall_now = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                left = 0;
            end
            if (sink_quiet) begin
                stall_now = 1'b0;
                left = 0;
            end else if (left > 0) begin
                left--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    stall_now = 1'b0;
                    left = $urandom_range(0, 7);
                end else if (r < 95) begin
                    stall_now = 1'b1;
                    left = $urandom_range(0, 2);
                end else begin
                    stall_now = 1'b1;
                    left = $urandom_range(10, 40);
                end
            end
            i_stall <= stall_now;
        end
    end

    function automatic t_word rand_word();
        case ($urandom_range(0, 9))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return '0;
            3: return ONE_Q16;
            4: return 32'hFFFF_0000;
            5, 6: return $urandom;
            default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        endcase
    endfunction

    task automatic send_vec(input t_word x, input t_word y, input t_word z, input t_word w);
        t_word v [4];
        v = '{x, y, z, w};
        i_valid <= 1'b1;
        i_vec_x <= x;
        i_vec_y <= y;
        i_vec_z <= z;
        i_vec_w <= w;
        do @(posedge i_clk); while (o_stall);
        tracker.note_vector(v);
    endtask

    task automatic source_gap();
        int r;
        int gap;
        r = $urandom_range(0, 99);
        if (src_quiet || r < 55)
            gap = 0;
        else if (r < 92)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 30);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_random(input int count);
        repeat (count) begin
            send_vec(rand_word(), rand_word(), rand_word(), rand_word());
            source_gap();
        end
    endtask

    // Lower valid and wait for every outstanding result, then let the pipe settle.
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [3:0] idx, input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.write_reg(idx, data);
        reg_writes++;
    endtask

    // Write all eight registers in shuffled order, sometimes with a stray
    // write to an unused index mixed in.
    task automatic load_matrix(input logic [63:0] regs_in [8]);
        int order [8];
        int j;
        int tmp;
        for (int k = 0; k < 8; k++)
            order[k] = k;
        for (int k = 7; k > 0; k--) begin
            j = $urandom_range(0, k);
            tmp = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        for (int k = 0; k < 8; k++) begin
            cfg_write(4'(order[k]), regs_in[order[k]]);
            if ($urandom_range(0, 5) == 0)
                cfg_write(4'd8 + 4'($urandom_range(0, 7)), {$urandom, $urandom});
        end
        i_cfg_valid <= 1'b0;
        settings++;
    endtask

    initial begin : main_seq
        logic [63:0] regs [8];

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // identity matrix out of reset
        send_vec('0, '0, '0, '0);
        send_vec(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
        source_gap();
        send_vec(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
        send_vec(32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_8000, 32'hFFFF_8000);
        send_vec(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_F0F0, 32'hF0F0_0F0F);
        drain();

        // half-ulp row for flooring, full-scale rows for both saturations,
        // and a row whose products cancel only in the wide sum
        regs = '{{32'h0, 32'h0000_8000}, 64'h0,
                 {WORD_MAX, WORD_MAX}, {WORD_MAX, WORD_MAX},
                 {WORD_MIN, WORD_MIN}, {WORD_MIN, WORD_MIN},
                 {WORD_MAX, WORD_MAX}, {WORD_MIN, WORD_MIN}};
        load_matrix(regs);
        send_vec(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_vec(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
        send_vec(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
        source_gap();
        send_vec(32'h0000_0001, '0, '0, '0);
        send_vec(32'hFFFF_FFFF, '0, '0, '0);
        send_vec(WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN);
        send_vec(rand_word(), rand_word(), rand_word(), rand_word());
        drain();

        regs = '{default: 64'h0};
        load_matrix(regs);
        send_vec(WORD_MAX, WORD_MIN, 32'hFFFF_FFFF, ONE_Q16);
        send_vec(rand_word(), rand_word(), rand_word(), rand_word());
        drain();

        // every element minus one ulp
        regs = '{default: 64'hFFFF_FFFF_FFFF_FFFF};
        load_matrix(regs);
        send_vec(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
        send_vec(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
        send_vec(32'h0000_0001, '0, '0, '0);
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            for (int k = 0; k < 8; k++)
                regs[k] = {rand_word(), rand_word()};
            load_matrix(regs);
            src_quiet  = (ph % 4 == 3);
            sink_quiet = (ph % 4 == 3);
            if (ph == 1) begin
                // fill the pipe against a held output
                src_quiet = 1'b1;
                hold_req  = 1'b1;
                send_random(24);
                src_quiet = 1'b0;
                send_random(PHASE_VECTORS - 24);
            end else if (ph == 2) begin
                send_random(PHASE_VECTORS / 2);
                i_valid <= 1'b0;
                do @(posedge i_clk); while (tracker.pending() != 0);
                send_random(PHASE_VECTORS - PHASE_VECTORS / 2);
            end else begin
                send_random(PHASE_VECTORS);
            end
            drain();
        end

        $display("Transformed %0d vectors under %0d matrix settings (%0d register writes,",
                 tracker.vectors_seen, settings, reg_writes);
        $display("  unused indexes included), with random and long output stalls.");
        if (tracker.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
